### src/assert_macros.svh
// Concurrent assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while the asynchronous reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also applies during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/hpd_pkg.sv
package hpd_pkg;

	localparam int NUM_SYMS = 256;
	localparam int CODE_W   = 30;
	localparam int LEN_W    = 5;
	localparam int MAX_LEN  = 30;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 3;
	localparam int PAD_MAX  = 8;

	localparam logic KIND_SYMBOL = 1'b0;
	localparam logic KIND_END    = 1'b1;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_BAD_CODE = 2'd1;
	localparam logic [1:0] STS_PAD_LONG = 2'd2;
	localparam logic [1:0] STS_PAD_ZERO = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] symbol;
		logic [1:0] status;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITS,
		ST_STATUS,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic code_bit;
		logic step;
		logic restart;
	} walk_ctl_t;

	typedef struct packed {
		logic       hit;
		logic       err;
		logic [7:0] symbol;
		logic [1:0] pad_status;
	} walk_sts_t;

	typedef struct packed {
		logic      push;
		logic      flush;
		out_item_t item;
	} buf_ctl_t;

	typedef struct packed {
		logic can_push;
		logic flush_ok;
	} buf_sts_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hcode_t;

	typedef logic [MAX_LEN:0][CODE_W-1:0] first_tab_t;
	typedef logic [MAX_LEN:0][8:0]        count_tab_t;
	typedef logic [MAX_LEN:0][7:0]        base_tab_t;
	typedef logic [NUM_SYMS-1:0][7:0]     sym_tab_t;

	// Standard HPACK code table, indexed by symbol; EOS is not included.
	localparam hcode_t HUFF_TAB [NUM_SYMS] = '{
		{30'h1ff8,5'd13}, {30'h7fffd8,5'd23}, {30'hfffffe2,5'd28}, {30'hfffffe3,5'd28},
		{30'hfffffe4,5'd28}, {30'hfffffe5,5'd28}, {30'hfffffe6,5'd28}, {30'hfffffe7,5'd28},
		{30'hfffffe8,5'd28}, {30'hffffea,5'd24}, {30'h3ffffffc,5'd30}, {30'hfffffe9,5'd28},
		{30'hfffffea,5'd28}, {30'h3ffffffd,5'd30}, {30'hfffffeb,5'd28}, {30'hfffffec,5'd28},
		{30'hfffffed,5'd28}, {30'hfffffee,5'd28}, {30'hfffffef,5'd28}, {30'hffffff0,5'd28},
		{30'hffffff1,5'd28}, {30'hffffff2,5'd28}, {30'h3ffffffe,5'd30}, {30'hffffff3,5'd28},
		{30'hffffff4,5'd28}, {30'hffffff5,5'd28}, {30'hffffff6,5'd28}, {30'hffffff7,5'd28},
		{30'hffffff8,5'd28}, {30'hffffff9,5'd28}, {30'hffffffa,5'd28}, {30'hffffffb,5'd28},
		{30'h14,5'd6}, {30'h3f8,5'd10}, {30'h3f9,5'd10}, {30'hffa,5'd12},
		{30'h1ff9,5'd13}, {30'h15,5'd6}, {30'hf8,5'd8}, {30'h7fa,5'd11},
		{30'h3fa,5'd10}, {30'h3fb,5'd10}, {30'hf9,5'd8}, {30'h7fb,5'd11},
		{30'hfa,5'd8}, {30'h16,5'd6}, {30'h17,5'd6}, {30'h18,5'd6},
		{30'h0,5'd5}, {30'h1,5'd5}, {30'h2,5'd5}, {30'h19,5'd6},
		{30'h1a,5'd6}, {30'h1b,5'd6}, {30'h1c,5'd6}, {30'h1d,5'd6},
		{30'h1e,5'd6}, {30'h1f,5'd6}, {30'h5c,5'd7}, {30'hfb,5'd8},
		{30'h7ffc,5'd15}, {30'h20,5'd6}, {30'hffb,5'd12}, {30'h3fc,5'd10},
		{30'h1ffa,5'd13}, {30'h21,5'd6}, {30'h5d,5'd7}, {30'h5e,5'd7},
		{30'h5f,5'd7}, {30'h60,5'd7}, {30'h61,5'd7}, {30'h62,5'd7},
		{30'h63,5'd7}, {30'h64,5'd7}, {30'h65,5'd7}, {30'h66,5'd7},
		{30'h67,5'd7}, {30'h68,5'd7}, {30'h69,5'd7}, {30'h6a,5'd7},
		{30'h6b,5'd7}, {30'h6c,5'd7}, {30'h6d,5'd7}, {30'h6e,5'd7},
		{30'h6f,5'd7}, {30'h70,5'd7}, {30'h71,5'd7}, {30'h72,5'd7},
		{30'hfc,5'd8}, {30'h73,5'd7}, {30'hfd,5'd8}, {30'h1ffb,5'd13},
		{30'h7fff0,5'd19}, {30'h1ffc,5'd13}, {30'h3ffc,5'd14}, {30'h22,5'd6},
		{30'h7ffd,5'd15}, {30'h3,5'd5}, {30'h23,5'd6}, {30'h4,5'd5},
		{30'h24,5'd6}, {30'h5,5'd5}, {30'h25,5'd6}, {30'h26,5'd6},
		{30'h27,5'd6}, {30'h6,5'd5}, {30'h74,5'd7}, {30'h75,5'd7},
		{30'h28,5'd6}, {30'h29,5'd6}, {30'h2a,5'd6}, {30'h7,5'd5},
		{30'h2b,5'd6}, {30'h76,5'd7}, {30'h2c,5'd6}, {30'h8,5'd5},
		{30'h9,5'd5}, {30'h2d,5'd6}, {30'h77,5'd7}, {30'h78,5'd7},
		{30'h79,5'd7}, {30'h7a,5'd7}, {30'h7b,5'd7}, {30'h7ffe,5'd15},
		{30'h7fc,5'd11}, {30'h3ffd,5'd14}, {30'h1ffd,5'd13}, {30'hffffffc,5'd28},
		{30'hfffe6,5'd20}, {30'h3fffd2,5'd22}, {30'hfffe7,5'd20}, {30'hfffe8,5'd20},
		{30'h3fffd3,5'd22}, {30'h3fffd4,5'd22}, {30'h3fffd5,5'd22}, {30'h7fffd9,5'd23},
		{30'h3fffd6,5'd22}, {30'h7fffda,5'd23}, {30'h7fffdb,5'd23}, {30'h7fffdc,5'd23},
		{30'h7fffdd,5'd23}, {30'h7fffde,5'd23}, {30'hffffeb,5'd24}, {30'h7fffdf,5'd23},
		{30'hffffec,5'd24}, {30'hffffed,5'd24}, {30'h3fffd7,5'd22}, {30'h7fffe0,5'd23},
		{30'hffffee,5'd24}, {30'h7fffe1,5'd23}, {30'h7fffe2,5'd23}, {30'h7fffe3,5'd23},
		{30'h7fffe4,5'd23}, {30'h1fffdc,5'd21}, {30'h3fffd8,5'd22}, {30'h7fffe5,5'd23},
		{30'h3fffd9,5'd22}, {30'h7fffe6,5'd23}, {30'h7fffe7,5'd23}, {30'hffffef,5'd24},
		{30'h3fffda,5'd22}, {30'h1fffdd,5'd21}, {30'hfffe9,5'd20}, {30'h3fffdb,5'd22},
		{30'h3fffdc,5'd22}, {30'h7fffe8,5'd23}, {30'h7fffe9,5'd23}, {30'h1fffde,5'd21},
		{30'h7fffea,5'd23}, {30'h3fffdd,5'd22}, {30'h3fffde,5'd22}, {30'hfffff0,5'd24},
		{30'h1fffdf,5'd21}, {30'h3fffdf,5'd22}, {30'h7fffeb,5'd23}, {30'h7fffec,5'd23},
		{30'h1fffe0,5'd21}, {30'h1fffe1,5'd21}, {30'h3fffe0,5'd22}, {30'h1fffe2,5'd21},
		{30'h7fffed,5'd23}, {30'h3fffe1,5'd22}, {30'h7fffee,5'd23}, {30'h7fffef,5'd23},
		{30'hfffea,5'd20}, {30'h3fffe2,5'd22}, {30'h3fffe3,5'd22}, {30'h3fffe4,5'd22},
		{30'h7ffff0,5'd23}, {30'h3fffe5,5'd22}, {30'h3fffe6,5'd22}, {30'h7ffff1,5'd23},
		{30'h3ffffe0,5'd26}, {30'h3ffffe1,5'd26}, {30'hfffeb,5'd20}, {30'h7fff1,5'd19},
		{30'h3fffe7,5'd22}, {30'h7ffff2,5'd23}, {30'h3fffe8,5'd22}, {30'h1ffffec,5'd25},
		{30'h3ffffe2,5'd26}, {30'h3ffffe3,5'd26}, {30'h3ffffe4,5'd26}, {30'h7ffffde,5'd27},
		{30'h7ffffdf,5'd27}, {30'h3ffffe5,5'd26}, {30'hfffff1,5'd24}, {30'h1ffffed,5'd25},
		{30'h7fff2,5'd19}, {30'h1fffe3,5'd21}, {30'h3ffffe6,5'd26}, {30'h7ffffe0,5'd27},
		{30'h7ffffe1,5'd27}, {30'h3ffffe7,5'd26}, {30'h7ffffe2,5'd27}, {30'hfffff2,5'd24},
		{30'h1fffe4,5'd21}, {30'h1fffe5,5'd21}, {30'h3ffffe8,5'd26}, {30'h3ffffe9,5'd26},
		{30'hffffffd,5'd28}, {30'h7ffffe3,5'd27}, {30'h7ffffe4,5'd27}, {30'h7ffffe5,5'd27},
		{30'hfffec,5'd20}, {30'hfffff3,5'd24}, {30'hfffed,5'd20}, {30'h1fffe6,5'd21},
		{30'h3fffe9,5'd22}, {30'h1fffe7,5'd21}, {30'h1fffe8,5'd21}, {30'h7ffff3,5'd23},
		{30'h3fffea,5'd22}, {30'h3fffeb,5'd22}, {30'h1ffffee,5'd25}, {30'h1ffffef,5'd25},
		{30'hfffff4,5'd24}, {30'hfffff5,5'd24}, {30'h3ffffea,5'd26}, {30'h7ffff4,5'd23},
		{30'h3ffffeb,5'd26}, {30'h7ffffe6,5'd27}, {30'h3ffffec,5'd26}, {30'h3ffffed,5'd26},
		{30'h7ffffe7,5'd27}, {30'h7ffffe8,5'd27}, {30'h7ffffe9,5'd27}, {30'h7ffffea,5'd27},
		{30'h7ffffeb,5'd27}, {30'hffffffe,5'd28}, {30'h7ffffec,5'd27}, {30'h7ffffed,5'd27},
		{30'h7ffffee,5'd27}, {30'h7ffffef,5'd27}, {30'h7fffff0,5'd27}, {30'h3ffffee,5'd26}
	};

	// The code is canonical: per length, codes are consecutive and follow symbol order.
	// These tables are derived from the code table at elaboration.
	function automatic first_tab_t build_first_tab();
		first_tab_t t;
		for (int l = 0; l <= MAX_LEN; l++) begin
			t[l] = '1;
		end
		for (int s = 0; s < NUM_SYMS; s++) begin
			if (HUFF_TAB[s].code < t[HUFF_TAB[s].len]) begin
				t[HUFF_TAB[s].len] = HUFF_TAB[s].code;
			end
		end
		return t;
	endfunction

	function automatic count_tab_t build_count_tab();
		count_tab_t t;
		t = '0;
		for (int s = 0; s < NUM_SYMS; s++) begin
			t[HUFF_TAB[s].len] = t[HUFF_TAB[s].len] + 9'd1;
		end
		return t;
	endfunction

	localparam first_tab_t FIRST_TAB = build_first_tab();
	localparam count_tab_t COUNT_TAB = build_count_tab();

	function automatic count_tab_t build_offset_tab();
		count_tab_t t;
		logic [8:0] acc;
		acc = '0;
		for (int l = 0; l <= MAX_LEN; l++) begin
			t[l] = acc;
			acc = acc + COUNT_TAB[l];
		end
		return t;
	endfunction

	localparam count_tab_t OFFSET_TAB = build_offset_tab();

	// Sorted-list index of a code is its low byte minus this per-length base.
	function automatic base_tab_t build_base_tab();
		base_tab_t t;
		for (int l = 0; l <= MAX_LEN; l++) begin
			t[l] = FIRST_TAB[l][7:0] - OFFSET_TAB[l][7:0];
		end
		return t;
	endfunction

	function automatic sym_tab_t build_sym_tab();
		sym_tab_t t;
		count_tab_t pos;
		t = '0;
		pos = OFFSET_TAB;
		for (int s = 0; s < NUM_SYMS; s++) begin
			t[pos[HUFF_TAB[s].len][7:0]] = 8'(s);
			pos[HUFF_TAB[s].len] = pos[HUFF_TAB[s].len] + 9'd1;
		end
		return t;
	endfunction

	localparam base_tab_t BASE_TAB = build_base_tab();
	localparam sym_tab_t  SYM_TAB  = build_sym_tab();

endpackage

### src/hpd_walk.sv
`include "assert_macros.svh"

module hpd_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  hpd_pkg::walk_ctl_t ctl,
	output hpd_pkg::walk_sts_t sts
);
	import hpd_pkg::*;

	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  len_q;
	logic              ones_q;

	logic [CODE_W-1:0] code_next;
	logic [LEN_W-1:0]  len_next;
	logic [CODE_W-1:0] diff;
	logic [7:0]        sym_idx;
	logic              hit;
	logic              err;

	// One code bit per use: extend the code and test it against its length class.
	always_comb begin
		code_next = {code_q[CODE_W-2:0], ctl.code_bit};
		len_next  = len_q + LEN_W'(1);
		diff      = code_next - FIRST_TAB[len_next];
		hit       = diff < CODE_W'(COUNT_TAB[len_next]);
		sym_idx   = code_next[7:0] - BASE_TAB[len_next];
		err       = !hit && (len_next >= LEN_W'(MAX_LEN));
	end

	always_comb begin
		sts.hit    = hit;
		sts.err    = err;
		sts.symbol = SYM_TAB[sym_idx];
		if (len_q >= LEN_W'(PAD_MAX)) begin
			sts.pad_status = STS_PAD_LONG;
		end else if ((len_q != '0) && !ones_q) begin
			sts.pad_status = STS_PAD_ZERO;
		end else begin
			sts.pad_status = STS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			len_q  <= '0;
			ones_q <= 1'b1;
		end else if (ctl.restart || (ctl.step && (hit || err))) begin
			code_q <= '0;
			len_q  <= '0;
			ones_q <= 1'b1;
		end else if (ctl.step) begin
			code_q <= code_next;
			len_q  <= len_next;
			ones_q <= ones_q & ctl.code_bit;
		end
	end

	`ASSERT_CLK(a_walk_restart, (ctl.step && (hit || err)) |=> (len_q == '0 && ones_q), "walk did not restart after a code ended")
	`ASSERT_CLK(a_walk_len, len_q < LEN_W'(MAX_LEN), "pending code reached maximum length")

endmodule

### src/hpd_out_buf.sv
`include "assert_macros.svh"

module hpd_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  hpd_pkg::buf_ctl_t  ctl,
	output hpd_pkg::buf_sts_t  sts,
	output logic               out_valid,
	input  logic               out_ready,
	output hpd_pkg::out_item_t out_data
);
	import hpd_pkg::*;

	// The newest result waits here until it is known whether it ends its byte.
	logic      pend_valid_q;
	out_item_t pend_q;
	logic      out_valid_q;
	out_item_t out_q;
	logic      out_free;
	out_item_t push_item;
	out_item_t flush_item;

	assign out_free     = !out_valid_q || out_ready;
	assign sts.can_push = !pend_valid_q || out_free;
	assign sts.flush_ok = !pend_valid_q || out_free;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	always_comb begin
		push_item              = ctl.item;
		push_item.last_of_run  = 1'b0;
		flush_item             = pend_q;
		flush_item.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.push && sts.can_push) begin
				pend_valid_q <= 1'b1;
				out_valid_q  <= pend_valid_q || (out_valid_q && !out_ready);
			end else if (ctl.flush && pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && sts.can_push) begin
			pend_q <= push_item;
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
		end else if (ctl.flush && pend_valid_q && out_free) begin
			out_q <= flush_item;
		end
	end

	`ASSERT_CLK(a_flush_marks_last, (ctl.flush && pend_valid_q && out_free && !ctl.push) |=> (out_valid_q && out_q.last_of_run && !pend_valid_q), "flushed item not marked last")
	`ASSERT_CLK(a_push_moves_pend, (ctl.push && pend_valid_q && out_free) |=> (out_valid_q && !out_q.last_of_run), "pending item lost on push")

endmodule

### src/hpack_huffman_decoder.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data  (data_byte, last_byte)
// out     | output    | out_valid / out_ready  | out_data (kind, symbol, status, last_of_run)
//
// Sequence: a byte is taken while the sequencer is idle, then walked one code bit per cycle
// (unless a result must wait) through the shared canonical-code compare unit, and the
// ST_FLUSH state releases the final result; the last byte of a string first passes through
// ST_STATUS, which adds the end status. An invalid code ends the walk at that bit, bypassing ST_STATUS.
// A byte that is skipped after an invalid code is taken without a bit walk.
// Reset: arst_n clears the walk, the skip flag, the sequencer and the valid flags of both
// result registers.
// Stalls: with the result registers full, a bit that yields a result holds the walk until
// out_ready frees them; in_ready is high only while the sequencer waits for a new byte.
`include "assert_macros.svh"

module hpack_huffman_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hpd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hpd_pkg::out_item_t out_data
);
	import hpd_pkg::*;

	state_t            state_q;
	state_t            state_next;
	logic [7:0]        byte_q;
	logic              last_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              dropping_q;

	walk_ctl_t walk_ctl;
	walk_sts_t walk_sts;
	buf_ctl_t  buf_ctl;
	buf_sts_t  buf_sts;

	logic accept;
	logic emit;

	assign accept = in_valid && in_ready;
	// A bit that completes a code, or runs into the end-of-string code, yields a result.
	assign emit   = walk_sts.hit || walk_sts.err;

	hpd_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.sts    (walk_sts)
	);

	hpd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (buf_ctl),
		.sts       (buf_sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !dropping_q) begin
					state_next = ST_BITS;
				end
			end
			ST_BITS: begin
				if (walk_ctl.step) begin
					if (walk_sts.err) begin
						state_next = ST_FLUSH;
					end else if (cnt_q == CNT_W'(BYTE_W - 1)) begin
						state_next = last_q ? ST_STATUS : ST_FLUSH;
					end
				end
			end
			ST_STATUS: begin
				if (buf_sts.can_push) begin
					state_next = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (buf_sts.flush_ok) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready          = 1'b0;
		walk_ctl.code_bit = byte_q[7];
		walk_ctl.step     = 1'b0;
		walk_ctl.restart  = 1'b0;
		buf_ctl.push      = 1'b0;
		buf_ctl.flush     = 1'b0;
		buf_ctl.item      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// The last byte of a string that is being skipped resets the walk.
				if (accept && dropping_q && in_data.last_byte) begin
					walk_ctl.restart = 1'b1;
				end
			end
			ST_BITS: begin
				walk_ctl.step = !emit || buf_sts.can_push;
				buf_ctl.push  = emit && buf_sts.can_push;
				if (walk_sts.err) begin
					buf_ctl.item.kind   = KIND_END;
					buf_ctl.item.status = STS_BAD_CODE;
				end else begin
					buf_ctl.item.kind   = KIND_SYMBOL;
					buf_ctl.item.symbol = walk_sts.symbol;
				end
			end
			ST_STATUS: begin
				buf_ctl.push        = buf_sts.can_push;
				buf_ctl.item.kind   = KIND_END;
				buf_ctl.item.status = walk_sts.pad_status;
				walk_ctl.restart    = buf_sts.can_push;
			end
			ST_FLUSH: begin
				buf_ctl.flush = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			dropping_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				cnt_q  <= '0;
				last_q <= in_data.last_byte;
				if (dropping_q && in_data.last_byte) begin
					dropping_q <= 1'b0;
				end
			end else if (walk_ctl.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
				// An invalid code skips the rest of the string unless this byte ends it.
				if (walk_sts.err) begin
					dropping_q <= !last_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_data.data_byte;
		end else if (walk_ctl.step) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
	end

	`ASSERT_CLK(a_byte_done, (walk_ctl.step && cnt_q == CNT_W'(BYTE_W - 1)) |=> (state_q != ST_BITS), "bit walk ran past the end of a byte")
	`ASSERT_CLK(a_err_leaves, (walk_ctl.step && walk_sts.err) |=> (state_q == ST_FLUSH && dropping_q == !$past(last_q)), "invalid code not handled")
	`ASSERT_ALWAYS(a_ready_idle, !in_ready || (state_q == ST_IDLE), "byte taken while busy")

endmodule

### test/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hpd_pkg::*;

	// Run length and pacing. About 370 bytes are sent; the calm window and the
	// long output hold-off both fall well inside the run.
	localparam int ITEM_TARGET    = 370;
	localparam int IDLE_PCT       = 15;
	localparam int CALM_FROM      = 800;
	localparam int CALM_TO        = 1600;
	localparam int HOLD_AT        = 2000;
	localparam int HOLD_LEN       = 300;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT   = 10;

	// The longest code in the table is 30 bits. Padding of PAD_LIMIT bits or
	// more is rejected at the end of a string.
	localparam int CODE_MAX  = 30;
	localparam int PAD_LIMIT = 8;

	// The digit '0' has a 5-bit code of all zeros.
	localparam logic [7:0] SYM_DIGIT_ZERO = 8'h30;
	localparam logic [7:0] SYM_LOWER_A    = 8'h61;

	localparam out_item_t NO_RES = '0;

	// Code length of every symbol, in symbol order. The code is canonical, so
	// the code words themselves follow from the lengths alone.
	localparam int CODE_LEN [256] = '{
		13, 23, 28, 28, 28, 28, 28, 28,  28, 24, 30, 28, 28, 30, 28, 28,
		28, 28, 28, 28, 28, 28, 30, 28,  28, 28, 28, 28, 28, 28, 28, 28,
		 6, 10, 10, 12, 13,  6,  8, 11,  10, 10,  8, 11,  8,  6,  6,  6,
		 5,  5,  5,  6,  6,  6,  6,  6,   6,  6,  7,  8, 15,  6, 12, 10,
		13,  6,  7,  7,  7,  7,  7,  7,   7,  7,  7,  7,  7,  7,  7,  7,
		 7,  7,  7,  7,  7,  7,  7,  7,   8,  7,  8, 13, 19, 13, 14,  6,
		15,  5,  6,  5,  6,  5,  6,  6,   6,  5,  7,  7,  6,  6,  6,  5,
		 6,  7,  6,  5,  5,  6,  7,  7,   7,  7,  7, 15, 11, 14, 13, 28,
		20, 22, 20, 20, 22, 22, 22, 23,  22, 23, 23, 23, 23, 23, 24, 23,
		24, 24, 22, 23, 24, 23, 23, 23,  23, 21, 22, 23, 22, 23, 23, 24,
		22, 21, 20, 22, 22, 23, 23, 21,  23, 22, 22, 24, 21, 22, 23, 23,
		21, 21, 22, 21, 23, 22, 23, 23,  20, 22, 22, 22, 23, 22, 22, 23,
		26, 26, 20, 19, 22, 23, 22, 25,  26, 26, 26, 27, 27, 26, 24, 25,
		19, 21, 26, 27, 27, 26, 27, 24,  21, 21, 26, 26, 28, 27, 27, 27,
		20, 24, 20, 21, 22, 21, 21, 23,  22, 22, 25, 25, 24, 24, 26, 23,
		26, 27, 26, 26, 27, 27, 27, 27,  27, 28, 27, 27, 27, 27, 27, 26
	};

	// One row of the directed table. A typed row carries its results as they
	// can be read straight off the code table; other rows go to the predictor.
	typedef struct packed {
		in_item_t   stim;
		logic       typed;
		logic [1:0] n_res;
		out_item_t  r0;
		out_item_t  r1;
		out_item_t  r2;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	hpack_huffman_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Canonical code tables, filled once at the start of the run.
	logic [29:0] code_of     [256];
	logic [7:0]  sym_by_rank [256];
	logic [31:0] first_code  [CODE_MAX+1];
	int          len_count   [CODE_MAX+1];
	int          rank_base   [CODE_MAX+1];

	// Decoder state as the predictor sees it.
	logic [29:0] walk_code;
	int          walk_len;
	logic        walk_ones;
	logic        skipping;

	out_item_t results_due [$];     // results still to come, oldest first
	dir_row_t  bytes_in_flight [$]; // items offered but not yet taken
	bit        str_bits [$];        // coded bits of the string being built

	int   bytes_taken;
	int   fault_count;
	int   cyc = 0;
	int   quiet = 0;
	logic calm;

	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	function automatic out_item_t mk_res(logic kind_v, logic [7:0] sym_v, logic [1:0] st_v,
			logic lo_v);
		out_item_t r;
		r.kind        = kind_v;
		r.symbol      = sym_v;
		r.status      = st_v;
		r.last_of_run = lo_v;
		return r;
	endfunction

	function automatic dir_row_t row_typed(logic [7:0] dbyte, logic lst, logic [1:0] n,
			out_item_t a, out_item_t b, out_item_t c);
		dir_row_t r;
		r.stim.data_byte = dbyte;
		r.stim.last_byte = lst;
		r.typed = 1'b1;
		r.n_res = n;
		r.r0 = a;
		r.r1 = b;
		r.r2 = c;
		return r;
	endfunction

	function automatic dir_row_t row_pred(logic [7:0] dbyte, logic lst);
		dir_row_t r;
		r = '0;
		r.stim.data_byte = dbyte;
		r.stim.last_byte = lst;
		return r;
	endfunction

	// Codes are handed out in order of length, then symbol, starting at zero.
	// After each length the running code is doubled, as a canonical code needs.
	function automatic void build_code_table();
		logic [31:0] code;
		int k;
		code = '0;
		k = 0;
		for (int l = 0; l <= CODE_MAX; l++) begin
			first_code[l] = code;
			rank_base[l] = k;
			len_count[l] = 0;
			for (int s = 0; s < 256; s++) begin
				if (CODE_LEN[s] == l) begin
					sym_by_rank[k] = 8'(s);
					code_of[s] = code[29:0];
					code = code + 1;
					k++;
					len_count[l]++;
				end
			end
			code = code << 1;
		end
	endfunction

	function automatic void walk_restart();
		walk_code = '0;
		walk_len = 0;
		walk_ones = 1'b1;
	endfunction

	function automatic void queue_result(out_item_t r);
		results_due.insert(results_due.size(), r);
	endfunction

	function automatic void drop_newest();
		results_due.delete(results_due.size() - 1);
	endfunction

	function automatic void add_bit(bit b);
		str_bits.insert(str_bits.size(), b);
	endfunction

	// Walks one coded byte, most significant bit first, and queues the results
	// that it causes. Returns how many were queued.
	function automatic int huff_decode_byte(in_item_t it);
		int n;
		bit was_skip;
		bit errored;
		logic b;
		logic [31:0] ofs;
		logic [1:0] st;
		out_item_t tail;
		n = 0;
		was_skip = skipping;
		errored = 1'b0;
		if (!was_skip) begin
			for (int i = 7; i >= 0; i--) begin
				b = it.data_byte[i];
				walk_code = {walk_code[28:0], b};
				walk_len++;
				if (!b) begin
					walk_ones = 1'b0;
				end
				// Thirty ones is the end-of-string code, which never stands
				// for a symbol inside the data.
				if (walk_len == CODE_MAX && (&walk_code)) begin
					queue_result(mk_res(KIND_END, 8'd0, STS_BAD_CODE, 1'b0));
					n++;
					walk_restart();
					if (!it.last_byte) begin
						skipping = 1'b1;
					end
					errored = 1'b1;
					break;
				end
				ofs = 32'(walk_code) - first_code[walk_len];
				if (32'(walk_code) >= first_code[walk_len] && ofs < 32'(len_count[walk_len]))
						begin
					queue_result(mk_res(KIND_SYMBOL,
						sym_by_rank[rank_base[walk_len] + int'(ofs)], STS_OK, 1'b0));
					n++;
					walk_restart();
				end
			end
		end
		if (it.last_byte) begin
			if (was_skip) begin
				skipping = 1'b0;
				walk_restart();
			end else if (!errored) begin
				if (walk_len >= PAD_LIMIT) begin
					st = STS_PAD_LONG;
				end else if (walk_len > 0 && !walk_ones) begin
					st = STS_PAD_ZERO;
				end else begin
					st = STS_OK;
				end
				queue_result(mk_res(KIND_END, 8'd0, st, 1'b0));
				n++;
				walk_restart();
			end
		end
		if (n > 0) begin
			tail = results_due[results_due.size() - 1];
			tail.last_of_run = 1'b1;
			results_due[results_due.size() - 1] = tail;
		end
		return n;
	endfunction

	function automatic void note_fault(string what, out_item_t want, out_item_t got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%0t %s: expected kind %0d symbol %02h status %0d last %0d,",
				$realtime, what, want.kind, want.symbol, want.status, want.last_of_run);
			$display("    got kind %0d symbol %02h status %0d last %0d",
				got.kind, got.symbol, got.status, got.last_of_run);
		end
	endfunction

	// Monitor for both channels. Every accepted input item runs through the
	// predictor; a typed directed row then stands in for what it predicted.
	// Every accepted result is checked against the oldest expectation.
	always @(posedge clk) begin
		dir_row_t rec;
		out_item_t want;
		out_item_t typed_res [3];
		int n;
		if (arst_n && in_valid && in_ready) begin
			rec = bytes_in_flight.pop_front();
			bytes_taken++;
			n = huff_decode_byte(in_data);
			if (rec.typed) begin
				repeat (n) begin
					drop_newest();
				end
				typed_res[0] = rec.r0;
				typed_res[1] = rec.r1;
				typed_res[2] = rec.r2;
				for (int i = 0; i < int'(rec.n_res); i++) begin
					queue_result(typed_res[i]);
				end
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				note_fault("unexpected result", NO_RES, out_data);
			end else begin
				want = results_due.pop_front();
				if (out_data.kind !== want.kind || out_data.symbol !== want.symbol ||
						out_data.status !== want.status ||
						out_data.last_of_run !== want.last_of_run) begin
					note_fault("result mismatch", want, out_data);
				end
			end
		end
	end

	// Watchdog: a stretch with no item taken on either channel means the
	// decoder has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side. Outside the calm window the receiver stalls at random, on
	// IDLE_PCT percent of cycles. Once, it holds off for a long stretch so that
	// the result registers fill and the decoder has to stop taking bytes.
	initial begin
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!held_once && cyc >= HOLD_AT) begin
				held_once = 1'b1;
				hold_left = HOLD_LEN;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Offers one item and returns at the edge where it is taken. Any idle gap
	// comes first, so valid is never lowered and raised in the same step.
	task automatic send_item(dir_row_t rec);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				gap++;
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= rec.stim;
		in_valid <= 1'b1;
		bytes_in_flight.insert(bytes_in_flight.size(), rec);
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	function automatic void put_code(logic [7:0] s);
		for (int i = CODE_LEN[s] - 1; i >= 0; i--) begin
			add_bit(code_of[s][i]);
		end
	endfunction

	function automatic void put_ones(int n);
		repeat (n) add_bit(1'b1);
	endfunction

	function automatic void put_rand(int n);
		repeat (n) add_bit(bit'($urandom_range(0, 1)));
	endfunction

	function automatic void pad_to_byte(bit ones);
		while (str_bits.size() % 8 != 0) begin
			add_bit(ones ? 1'b1 : bit'($urandom_range(0, 1)));
		end
	endfunction

	// Mostly printable text, which keeps codes short, with any octet at times
	// so that the long codes get their share.
	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(0, 99) < 70) begin
			return 8'($urandom_range(32, 126));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_string();
		int nb;
		logic [7:0] v;
		nb = str_bits.size() / 8;
		for (int j = 0; j < nb; j++) begin
			for (int k = 0; k < 8; k++) begin
				v[7-k] = str_bits[8*j + k];
			end
			send_item(row_pred(v, j == nb - 1));
		end
	endtask

	dir_row_t dir_tab [24];

	initial begin
		int pick;
		int padn;
		build_code_table();
		walk_restart();
		skipping = 1'b0;
		bytes_taken = 0;
		fault_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;

		dir_tab = '{
			// Eight ones with nothing decoded: padding too long.
			row_typed(8'hff, 1'b1, 2'd1, mk_res(KIND_END, 8'd0, STS_PAD_LONG, 1'b1),
				NO_RES, NO_RES),
			// Five zero bits are '0'; three zeros stay pending.
			row_typed(8'h00, 1'b0, 2'd1, mk_res(KIND_SYMBOL, SYM_DIGIT_ZERO, STS_OK, 1'b1),
				NO_RES, NO_RES),
			// Two more '0' and a single zero bit left as padding: the most
			// results one byte can cause.
			row_typed(8'h00, 1'b1, 2'd3, mk_res(KIND_SYMBOL, SYM_DIGIT_ZERO, STS_OK, 1'b0),
				mk_res(KIND_SYMBOL, SYM_DIGIT_ZERO, STS_OK, 1'b0),
				mk_res(KIND_END, 8'd0, STS_PAD_ZERO, 1'b1)),
			// "a" with three bits of proper padding.
			row_typed(8'h1f, 1'b1, 2'd2, mk_res(KIND_SYMBOL, SYM_LOWER_A, STS_OK, 1'b0),
				mk_res(KIND_END, 8'd0, STS_OK, 1'b1), NO_RES),
			// End-of-string code inside the data, then the rest is skipped.
			row_typed(8'hff, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES),
			row_typed(8'hff, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES),
			row_typed(8'hff, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES),
			row_typed(8'hfc, 1'b0, 2'd1, mk_res(KIND_END, 8'd0, STS_BAD_CODE, 1'b1),
				NO_RES, NO_RES),
			row_typed(8'h12, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES),
			row_typed(8'h34, 1'b1, 2'd0, NO_RES, NO_RES, NO_RES),
			// End-of-string code in the final byte: the error closes the string.
			row_typed(8'hff, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES),
			row_typed(8'hff, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES),
			row_typed(8'hff, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES),
			row_typed(8'hff, 1'b1, 2'd1, mk_res(KIND_END, 8'd0, STS_BAD_CODE, 1'b1),
				NO_RES, NO_RES),
			// A line feed, one of the 30-bit codes, then two padding ones.
			row_pred(8'hff, 1'b0),
			row_pred(8'hff, 1'b0),
			row_pred(8'hff, 1'b0),
			row_pred(8'hf3, 1'b1),
			// '0' and three padding ones.
			row_typed(8'h07, 1'b1, 2'd2, mk_res(KIND_SYMBOL, SYM_DIGIT_ZERO, STS_OK, 1'b0),
				mk_res(KIND_END, 8'd0, STS_OK, 1'b1), NO_RES),
			// Eight '0' that end exactly on the byte boundary: no padding.
			row_pred(8'h00, 1'b0),
			row_pred(8'h00, 1'b0),
			row_pred(8'h00, 1'b0),
			row_pred(8'h00, 1'b0),
			row_pred(8'h00, 1'b1)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i]);
		end

		// Random strings. Most are well formed with random text; the rest carry
		// bad padding, an end-of-string code in the middle, or plain noise.
		while (bytes_taken < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			str_bits.delete();
			if (pick < 60) begin
				repeat ($urandom_range(1, 6)) put_code(pick_symbol());
				pad_to_byte(1'b1);
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 6)) put_code(pick_symbol());
				if (str_bits.size() % 8 == 0) begin
					put_code(SYM_DIGIT_ZERO);
				end
				padn = 8 - str_bits.size() % 8;
				put_rand(padn);
				str_bits[str_bits.size() - 1 - $urandom_range(0, padn - 1)] = 1'b0;
			end else if (pick < 78) begin
				// A whole extra byte of ones makes the padding too long.
				repeat ($urandom_range(1, 6)) put_code(pick_symbol());
				pad_to_byte(1'b1);
				put_ones(8);
			end else if (pick < 88) begin
				repeat ($urandom_range(0, 3)) put_code(pick_symbol());
				put_ones(CODE_MAX);
				put_rand($urandom_range(0, 20));
				pad_to_byte(1'b0);
			end else begin
				put_rand(8 * $urandom_range(1, 5));
			end
			send_string();
		end
		in_valid <= 1'b0;

		// The last item's results are queued at the edge where it was taken.
		@(posedge clk);
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (results_due.size() != 0) begin
			note_fault("result never arrived", results_due[0], NO_RES);
		end
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/hpd_pkg.sv
src/hpd_walk.sv
src/hpd_out_buf.sv
src/hpack_huffman_decoder.sv
test/tb_top.sv
